// File: design/i2c_passive_bus_sniffer_defines.svh
// assertion macros for the bus sniffer checker
`ifndef I2C_PASSIVE_BUS_SNIFFER_DEFINES_SVH
`define I2C_PASSIVE_BUS_SNIFFER_DEFINES_SVH

// same-cycle implication
`define IPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ips_pkg.sv
`default_nettype none
package ips_pkg;

   localparam int FRAME_BYTES  = 16;
   localparam int QUEUE_FRAMES = 8;
   localparam int BITS_PER_SLOT = 9;

   // one spare slot so the frame being captured never overlaps a queued one
   localparam int SLOTS   = QUEUE_FRAMES + 1;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int POS_W   = $clog2(FRAME_BYTES);
   localparam int CNT_W   = $clog2(FRAME_BYTES + 1);
   localparam int FILL_W  = $clog2(QUEUE_FRAMES + 1);
   localparam int BYTE_AW = SLOT_W + POS_W;

   localparam int POS_FIELD_W = 4;
   localparam int LEN_FIELD_W = 5;

   typedef struct packed {
      logic on_clock;
      logic rising;
      logic clk_level;
      logic dat_level;
   } edge_type;

   typedef struct packed {
      logic               wr_en;
      logic [BYTE_AW-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic               commit;
      logic [CNT_W-1:0]   commit_len;
   } cap_out_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_LEN,
      RD_BYTE,
      RD_EMPTY
   } rd_state_type;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      r = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
      return r;
   endfunction

endpackage
`default_nettype wire

// File: design/i2c_passive_bus_sniffer.sv
// edge event: no result; next item the cycle after
// pop on empty queue: RD_EMPTY state, then the result is registered once the output is free
// pop of a frame: the length is read (RD_LEN), then the first byte (RD_BYTE),
// then one byte per cycle while rsp_ready, set by the single byte memory read port
// reset: capture and queue pointers cleared at once; byte and length memories keep
// their contents, no clearing pass
`default_nettype none
module i2c_passive_bus_sniffer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_cmd,
   input  wire logic       req_edge_on_clock,
   input  wire logic       req_edge_rising,
   input  wire logic       req_clock_level,
   input  wire logic       req_data_level,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_frame_valid,
   output logic [7:0]      rsp_frame_byte,
   output logic [3:0]      rsp_byte_position,
   output logic [4:0]      rsp_frame_length,
   output logic            rsp_last_of_frame
);
   import ips_pkg::*;

   logic              accept;
   logic              ev;
   logic              pop;
   edge_type          ev_edge;
   cap_out_type       cap;
   logic              pop_done;
   logic              idle;
   logic [BYTE_AW-1:0] byte_raddr;
   logic [7:0]        byte_rdata;
   logic [CNT_W-1:0]  len_rdata;

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign req_ready = idle;
   assign accept    = req_valid && req_ready;
   assign ev        = accept && !req_cmd;
   assign pop       = accept && req_cmd;

   assign ev_edge.on_clock  = req_edge_on_clock;
   assign ev_edge.rising    = req_edge_rising;
   assign ev_edge.clk_level = req_clock_level;
   assign ev_edge.dat_level = req_data_level;

   ips_capture u_capture (
      .clock   (clock),
      .reset   (reset),
      .ev      (ev),
      .ev_edge (ev_edge),
      .tail    (tail_ff),
      .cap     (cap)
   );

   ips_ram #(
      .WIDTH  (8),
      .ADDR_W (BYTE_AW)
   ) u_byte_ram (
      .clock (clock),
      .we    (cap.wr_en),
      .waddr (cap.wr_addr),
      .wdata (cap.wr_data),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

   ips_ram #(
      .WIDTH  (CNT_W),
      .ADDR_W (SLOT_W)
   ) u_len_ram (
      .clock (clock),
      .we    (cap.commit),
      .waddr (tail_ff),
      .wdata (cap.commit_len),
      .raddr (head_ff),
      .rdata (len_rdata)
   );

   ips_reader u_reader (
      .clock             (clock),
      .reset             (reset),
      .pop               (pop),
      .queue_empty       (fill_ff == '0),
      .head              (head_ff),
      .len_rdata         (len_rdata),
      .byte_rdata        (byte_rdata),
      .byte_raddr        (byte_raddr),
      .pop_done          (pop_done),
      .idle              (idle),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_valid   (rsp_frame_valid),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (cap.commit) begin
         tail_in = slot_inc(tail_ff);
         if (fill_ff == FILL_W'(QUEUE_FRAMES)) begin
            // full: oldest frame gives way
            head_in = slot_inc(head_ff);
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end else if (pop_done) begin
         head_in = slot_inc(head_ff);
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule
`default_nettype wire

// File: design/ips_ram.sv
`default_nettype none
module ips_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [(1 << ADDR_W)];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: design/ips_capture.sv
`default_nettype none
module ips_capture (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       ev,
   input  wire ips_pkg::edge_type          ev_edge,
   input  wire logic [ips_pkg::SLOT_W-1:0] tail,
   output ips_pkg::cap_out_type            cap
);
   import ips_pkg::*;

   logic             active_ff, active_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       shift_ff, shift_in;
   logic [3:0]       bits_ff, bits_in;

   always_comb begin
      active_in      = active_ff;
      count_in       = count_ff;
      shift_in       = shift_ff;
      bits_in        = bits_ff;
      cap.wr_en      = 1'b0;
      cap.wr_addr    = {tail, count_ff[POS_W-1:0]};
      cap.wr_data    = shift_ff;
      cap.commit     = 1'b0;
      cap.commit_len = count_ff;
      if (ev) begin
         if (!ev_edge.on_clock) begin
            if (ev_edge.clk_level) begin
               if (!ev_edge.rising) begin
                  // start or repeated start
                  active_in = 1'b1;
                  count_in  = '0;
                  shift_in  = '0;
                  bits_in   = '0;
               end else begin
                  // stop
                  cap.commit = active_ff && (count_ff != '0);
                  active_in  = 1'b0;
               end
            end
         end else if (ev_edge.rising && active_ff) begin
            if (bits_ff == 4'(BITS_PER_SLOT - 1)) begin
               // ninth bit is ack, byte sits in the shift register
               if (count_ff < CNT_W'(FRAME_BYTES)) begin
                  cap.wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               shift_in = '0;
               bits_in  = '0;
            end else begin
               shift_in = {shift_ff[6:0], ev_edge.dat_level};
               bits_in  = bits_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         shift_ff  <= '0;
         bits_ff   <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
      end
   end

endmodule
`default_nettype wire

// File: design/ips_reader.sv
`default_nettype none
module ips_reader (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pop,
   input  wire logic                        queue_empty,
   input  wire logic [ips_pkg::SLOT_W-1:0]  head,
   input  wire logic [ips_pkg::CNT_W-1:0]   len_rdata,
   input  wire logic [7:0]                  byte_rdata,
   output logic      [ips_pkg::BYTE_AW-1:0] byte_raddr,
   output logic                             pop_done,
   output logic                             idle,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_frame_valid,
   output logic      [7:0]                  rsp_frame_byte,
   output logic      [3:0]                  rsp_byte_position,
   output logic      [4:0]                  rsp_frame_length,
   output logic                             rsp_last_of_frame
);
   import ips_pkg::*;

   rd_state_type     state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic             out_free;
   logic             last;
   logic             load;
   logic             load_empty;

   logic       valid_ff;
   logic       fvalid_ff;
   logic [7:0] byte_ff;
   logic [3:0] position_ff;
   logic [4:0] length_ff;
   logic       lastf_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign last     = (CNT_W'(pos_ff) + CNT_W'(1)) == len_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RD_IDLE: begin
            if (pop) begin
               state_in = queue_empty ? RD_EMPTY : RD_LEN;
            end
         end
         RD_LEN: begin
            state_in = RD_BYTE;
         end
         RD_BYTE: begin
            if (out_free && last) begin
               state_in = RD_IDLE;
            end
         end
         RD_EMPTY: begin
            if (out_free) begin
               state_in = RD_IDLE;
            end
         end
         default: begin
            state_in = RD_IDLE;
         end
      endcase
   end

   always_comb begin
      idle       = 1'b0;
      load       = 1'b0;
      load_empty = 1'b0;
      pop_done   = 1'b0;
      pos_in     = pos_ff;
      len_in     = len_ff;
      unique case (state_ff)
         RD_IDLE: begin
            idle = 1'b1;
         end
         RD_LEN: begin
            len_in = len_rdata;
            pos_in = '0;
         end
         RD_BYTE: begin
            if (out_free) begin
               load = 1'b1;
               if (last) begin
                  pop_done = 1'b1;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
         end
         RD_EMPTY: begin
            load_empty = out_free;
         end
         default: begin
            idle = 1'b0;
         end
      endcase
   end

   assign byte_raddr = {head, pos_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RD_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load || load_empty) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      len_ff <= len_in;
      if (load) begin
         fvalid_ff   <= 1'b1;
         byte_ff     <= byte_rdata;
         position_ff <= POS_FIELD_W'(pos_ff);
         length_ff   <= LEN_FIELD_W'(len_ff);
         lastf_ff    <= last;
      end else if (load_empty) begin
         fvalid_ff   <= 1'b0;
         byte_ff     <= '0;
         position_ff <= '0;
         length_ff   <= '0;
         lastf_ff    <= 1'b1;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_valid   = fvalid_ff;
   assign rsp_frame_byte    = byte_ff;
   assign rsp_byte_position = position_ff;
   assign rsp_frame_length  = length_ff;
   assign rsp_last_of_frame = lastf_ff;

endmodule
`default_nettype wire

// File: design/ips_checker.sv
`default_nettype none
`include "i2c_passive_bus_sniffer_defines.svh"
module ips_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_frame_valid,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic [3:0] rsp_byte_position,
   input wire logic [4:0] rsp_frame_length,
   input wire logic       rsp_last_of_frame
);

   `IPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_byte_position)
      && $stable(rsp_last_of_frame), "result item changed while stalled")

   `IPS_ASSERT_NOW(a_empty_item, rsp_valid && !rsp_frame_valid,
      rsp_last_of_frame && (rsp_frame_length == 5'd0) && (rsp_byte_position == 4'd0)
      && (rsp_frame_byte == 8'd0), "malformed empty-queue item")

   `IPS_ASSERT_NOW(a_frame_item, rsp_valid && rsp_frame_valid,
      (rsp_frame_length != 5'd0)
      && (rsp_last_of_frame == ((5'(rsp_byte_position) + 5'd1) == rsp_frame_length)),
      "byte position and last flag disagree with frame length")

   `IPS_ASSERT_NOW(a_busy_streaming, rsp_valid && rsp_frame_valid && !rsp_last_of_frame,
      !req_ready, "new item taken in the middle of a frame")

   `IPS_ASSERT_NEXT(a_pop_busy, req_valid && req_ready && req_cmd, !req_ready,
      "new item taken right after a pop")

endmodule

bind i2c_passive_bus_sniffer ips_checker u_ips_checker (.*);
`default_nettype wire

// File: tb/i2c_passive_bus_sniffer_tb.sv
`default_nettype none
module i2c_passive_bus_sniffer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ips_pkg::*;

   localparam int FB = FRAME_BYTES;
   localparam int QF = QUEUE_FRAMES;
   localparam int LIMIT_CYCLES = 200000;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic cmd;
      logic on_clk;
      logic rising;
      logic clk_lvl;
      logic dat_lvl;
   } sniff_item_type;

   typedef struct packed {
      logic       fvalid;
      logic [7:0] fbyte;
      logic [3:0] pos;
      logic [4:0] len;
      logic       last;
   } sniff_rsp_type;

   logic clock;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = 1'b0;
   logic       req_edge_on_clock = 1'b0;
   logic       req_edge_rising = 1'b0;
   logic       req_clock_level = 1'b0;
   logic       req_data_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_frame_valid;
   logic [7:0] rsp_frame_byte;
   logic [3:0] rsp_byte_position;
   logic [4:0] rsp_frame_length;
   logic       rsp_last_of_frame;

   i2c_passive_bus_sniffer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_edge_on_clock (req_edge_on_clock),
      .req_edge_rising   (req_edge_rising),
      .req_clock_level   (req_clock_level),
      .req_data_level    (req_data_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_valid   (rsp_frame_valid),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   sniff_item_type pending_items[$];
   sniff_rsp_type  expected_rsp[$];

   int unsigned accepted = 0;
   int unsigned total_items = 0;
   int unsigned pops_sent = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;
   int unsigned frames_queued = 0;
   int unsigned frames_dropped = 0;
   int unsigned bytes_dropped = 0;
   int unsigned cycle_count = 0;

   // bus tracking state
   bit          cap_open = 1'b0;
   logic [7:0]  cap_buf [FB];
   int unsigned cap_len = 0;
   logic [8:0]  shreg = '0;
   int unsigned nbits = 0;
   logic [7:0]  held_bytes [QF][FB];
   int unsigned held_len [QF];
   int unsigned rd_ptr = 0;
   int unsigned wr_ptr = 0;
   int unsigned held_count = 0;

   task automatic track_item(input sniff_item_type it);
      sniff_rsp_type r;
      int unsigned n;
      int unsigned i;
      if (it.cmd) begin
         pops_sent++;
         if (held_count == 0) begin
            r = '0;
            r.last = 1'b1;
            expected_rsp.push_back(r);
         end else begin
            n = held_len[rd_ptr];
            for (i = 0; i < n; i++) begin
               r.fvalid = 1'b1;
               r.fbyte  = held_bytes[rd_ptr][i];
               r.pos    = i[3:0];
               r.len    = n[4:0];
               r.last   = (i + 1 == n);
               expected_rsp.push_back(r);
            end
            rd_ptr = (rd_ptr + 1) % QF;
            held_count--;
         end
      end else if (!it.on_clk) begin
         if (it.clk_lvl) begin
            if (!it.rising) begin
               cap_open = 1'b1;
               cap_len  = 0;
               shreg    = '0;
               nbits    = 0;
            end else begin
               if (cap_open && cap_len > 0) begin
                  // full queue loses its oldest frame
                  if (held_count >= QF) begin
                     rd_ptr = (rd_ptr + 1) % QF;
                     held_count--;
                     frames_dropped++;
                  end
                  for (i = 0; i < cap_len; i++) held_bytes[wr_ptr][i] = cap_buf[i];
                  held_len[wr_ptr] = cap_len;
                  wr_ptr = (wr_ptr + 1) % QF;
                  held_count++;
                  frames_queued++;
               end
               cap_open = 1'b0;
            end
         end
      end else if (it.rising && cap_open) begin
         shreg = {shreg[7:0], it.dat_lvl};
         nbits++;
         if (nbits == BITS_PER_SLOT) begin
            if (cap_len < FB) begin
               cap_buf[cap_len] = shreg[8:1];
               cap_len++;
            end else begin
               bytes_dropped++;
            end
            shreg = '0;
            nbits = 0;
         end
      end
   endtask

   function automatic void push_edge(bit on_clk, bit rising, bit clk_lvl, bit dat_lvl);
      sniff_item_type it;
      it.cmd     = 1'b0;
      it.on_clk  = on_clk;
      it.rising  = rising;
      it.clk_lvl = clk_lvl;
      it.dat_lvl = dat_lvl;
      pending_items.push_back(it);
   endfunction

   function automatic void push_pop();
      sniff_item_type it;
      it = sniff_item_type'(5'($urandom));
      it.cmd = 1'b1;
      pending_items.push_back(it);
   endfunction

   // start, bytes with ack bits, stop; unclean ones carry ignored edges and broken endings
   function automatic void add_transaction(int nbytes, bit clean);
      logic [7:0] value;
      logic [8:0] bits;
      int b;
      int k;
      int j;
      int shape;
      push_edge(1'b0, 1'b0, 1'b1, 1'b0);
      for (b = 0; b < nbytes; b++) begin
         case ($urandom_range(0, 9))
            0: value = 8'h00;
            1: value = 8'hFF;
            default: value = 8'($urandom);
         endcase
         bits = {value, 1'($urandom_range(0, 1))};
         for (k = 8; k >= 0; k--) begin
            if (!clean && $urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 1))
                  push_edge(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
               else
                  push_edge(1'b1, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            push_edge(1'b1, 1'b1, 1'b1, bits[k]);
            if (!clean && $urandom_range(0, 1)) push_edge(1'b1, 1'b0, 1'b0, bits[k]);
         end
      end
      shape = clean ? 15 : $urandom_range(0, 15);
      if (shape == 0) begin
         // trailing partial byte
         for (j = 0; j < $urandom_range(1, 8); j++)
            push_edge(1'b1, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
      end else if (shape == 1) begin
         // repeated start throws away the capture
         push_edge(1'b0, 1'b0, 1'b1, 1'b0);
         for (j = 0; j < $urandom_range(0, 8); j++)
            push_edge(1'b1, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
      end
      if (shape != 2) push_edge(1'b0, 1'b1, 1'b1, 1'b1);
   endfunction

   // sender
   sniff_item_type cur_item;
   int unsigned burst_left = 4;
   int unsigned gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_item(cur_item);
            accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               req_cmd           <= cur_item.cmd;
               req_edge_on_clock <= cur_item.on_clk;
               req_edge_rising   <= cur_item.rising;
               req_clock_level   <= cur_item.clk_lvl;
               req_data_level    <= cur_item.dat_lvl;
               req_valid         <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   int unsigned hold_left = 0;
   bit          held_once = 1'b0;
   int unsigned mode_left = 0;
   int unsigned stall_mode = 0;

   always @(posedge clock) begin : rsp_check
      sniff_rsp_type got;
      sniff_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_frame_valid, rsp_frame_byte, rsp_byte_position,
                   rsp_frame_length, rsp_last_of_frame};
            results_seen++;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: valid %0d byte %02h pos %0d len %0d last %0d",
                           got.fvalid, got.fbyte, got.pos, got.len, got.last);
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("item %0d: expected %0d/%02h/%0d/%0d/%0d got %0d/%02h/%0d/%0d/%0d",
                              results_seen, want.fvalid, want.fbyte, want.pos, want.len,
                              want.last, got.fvalid, got.fbyte, got.pos, got.len, got.last);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held_once && rsp_valid && results_seen >= 5) begin
            // long back-pressure so the block fills and stalls its input
            held_once = 1'b1;
            hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(5, 60);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int iter;
      int base;
      int r;
      int j;
      int nbytes;

      // directed: empty pop, ignored edges, lone stop, one full byte, empty frame
      pending_items.push_back(sniff_item_type'(5'b11111));
      push_edge(1'b0, 1'b1, 1'b1, 1'b1);
      push_edge(1'b0, 1'b0, 1'b0, 1'b1);
      push_edge(1'b0, 1'b1, 1'b0, 1'b0);
      push_edge(1'b1, 1'b1, 1'b1, 1'b1);
      push_edge(1'b1, 1'b0, 1'b1, 1'b0);
      push_edge(1'b0, 1'b0, 1'b1, 1'b0);
      for (j = 0; j < 8; j++) push_edge(1'b1, 1'b1, 1'b1, 1'b1);
      push_edge(1'b1, 1'b1, 1'b1, 1'b0);
      push_edge(1'b0, 1'b1, 1'b1, 1'b1);
      push_edge(1'b0, 1'b0, 1'b1, 1'b0);
      push_edge(1'b0, 1'b1, 1'b1, 1'b1);
      push_pop();
      push_pop();

      // random: mostly well-formed traffic mixed with pops and stray edges
      base = pending_items.size();
      iter = 0;
      while (pending_items.size() - base < 70) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
            add_transaction(nbytes, 1'b0);
         end else if (r < 85) begin
            for (j = 0; j < $urandom_range(1, 3); j++) push_pop();
         end else begin
            for (j = 0; j < $urandom_range(1, 4); j++) begin
               if ($urandom_range(0, 7) == 0) push_pop();
               else push_edge(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            end
         end
         iter++;
      end
      // capture overflow, then drain the queue past empty
      add_transaction(17, 1'b1);
      for (j = 0; j < QF + 1; j++) push_pop();
      total_items = pending_items.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted < total_items) @(posedge clock);
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d items with %0d pops, %0d result items checked",
               accepted, pops_sent, results_seen);
      $display("%0d frames queued, %0d lost to a full queue, %0d bytes past capture capacity",
               frames_queued, frames_dropped, bytes_dropped);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
`default_nettype wire
